[rtl/core/fnvrh_pkg.sv]
// ----------------------------------------------------------------------------
// fnvrh_pkg
// Shared types and constants for the FNV-1a 64-bit record hash core.
// ----------------------------------------------------------------------------
package fnvrh_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_BYTES = HASH_W / BYTE_W;
  localparam int unsigned CNT_W    = $clog2(WORD_BYTES);

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

  // Rounds left after the first byte, minus one (counter stops at zero).
  localparam logic [CNT_W-1:0] MIX_CNT_LOAD = CNT_W'(WORD_BYTES - 2);

  typedef enum logic [1:0] {
    FUNC_WORD  = 2'd0,
    FUNC_BOOL  = 2'd1,
    FUNC_EMPTY = 2'd2,
    FUNC_SKIP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_EMIT
  } state_t;

  // Result request from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] digest;
  } res_t;

endpackage

[rtl/core/fnvrh_mix_unit.sv]
// ----------------------------------------------------------------------------
// fnvrh_mix_unit
// One FNV-1a round: XOR a byte into the hash, multiply by the FNV prime.
// ----------------------------------------------------------------------------
module fnvrh_mix_unit
  import fnvrh_pkg::*;
(
  input  logic [HASH_W-1:0] hash_in,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [HASH_W-1:0] hash_out
);

  logic [HASH_W-1:0] x;

  assign x = hash_in ^ {{(HASH_W-BYTE_W){1'b0}}, byte_in};

  // prime = 2^40 + 2^8 + 0xB3, 0xB3 = 2^7 + 2^5 + 2^4 + 2^1 + 2^0
  assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                  + (x << 4) + (x << 1) + x;

endmodule

[rtl/core/fnvrh_seq.sv]
// ----------------------------------------------------------------------------
// fnvrh_seq
// Sequencer: holds the running hash and steps the shared mix unit once per
// byte of a word.
// ----------------------------------------------------------------------------
module fnvrh_seq
  import fnvrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [HASH_W-1:0] data_word,
  input  logic              first_field,
  input  logic              last_field,
  input  logic              slot_free,
  output res_t              res
);

  localparam int unsigned SHR_W = HASH_W - BYTE_W;

  state_t            state, state_next;
  logic [HASH_W-1:0] hash, hash_next;
  logic [SHR_W-1:0]  shreg, shreg_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              last_q, last_q_next;
  logic              pend_zero, pend_zero_next;

  logic [HASH_W-1:0] mix_in;
  logic [BYTE_W-1:0] mix_byte;
  logic [HASH_W-1:0] mix_out;
  func_t             fsel;

  assign fsel = func_t'(func);

  fnvrh_mix_unit u_mix (
    .hash_in  (mix_in),
    .byte_in  (mix_byte),
    .hash_out (mix_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hash  <= FNV_BASIS;
    end else begin
      state <= state_next;
      hash  <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    cnt       <= cnt_next;
    last_q    <= last_q_next;
    pend_zero <= pend_zero_next;
  end

  always_comb begin
    state_next     = state;
    hash_next      = hash;
    shreg_next     = shreg;
    cnt_next       = cnt;
    last_q_next    = last_q;
    pend_zero_next = pend_zero;
    mix_in         = hash;
    mix_byte       = shreg[BYTE_W-1:0];
    res.valid      = 1'b0;
    res.digest     = mix_out;
    in_ready       = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mix_in   = first_field ? FNV_BASIS : hash;
        mix_byte = (fsel == FUNC_BOOL) ? {{(BYTE_W-1){1'b0}}, data_word[0]}
                                       : data_word[BYTE_W-1:0];
        if (in_valid) begin
          case (fsel)
            FUNC_WORD: begin
              // first byte mixed on accept, the rest in ST_MIX
              hash_next   = mix_out;
              shreg_next  = data_word[HASH_W-1:BYTE_W];
              cnt_next    = MIX_CNT_LOAD;
              last_q_next = last_field;
              state_next  = ST_MIX;
            end
            FUNC_BOOL: begin
              hash_next = mix_out;
              if (last_field) begin
                res.valid      = 1'b1;
                pend_zero_next = 1'b0;
                if (!slot_free) state_next = ST_EMIT;
              end
            end
            FUNC_EMPTY: begin
              hash_next      = FNV_BASIS;
              res.valid      = 1'b1;
              res.digest     = '0;
              pend_zero_next = 1'b1;
              if (!slot_free) state_next = ST_EMIT;
            end
            default: ; // unused selector: dropped
          endcase
        end
      end

      ST_MIX: begin
        hash_next  = mix_out;
        shreg_next = {{BYTE_W{1'b0}}, shreg[SHR_W-1:BYTE_W]};
        cnt_next   = cnt - 1'b1;
        if (cnt == '0) begin
          if (last_q) begin
            res.valid      = 1'b1;
            pend_zero_next = 1'b0;
            state_next     = slot_free ? ST_IDLE : ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        res.valid  = 1'b1;
        res.digest = pend_zero ? '0 : hash;
        if (slot_free) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/fnv1a64_record_hash_core.sv]
// ----------------------------------------------------------------------------
// fnv1a64_record_hash_core
// Running FNV-1a 64-bit hash over a stream of record fields, one field word
// per input handshake, digest out on the last field or an empty run.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload                               dir
//  -------  -------------------  ------------------------------------  ---
//  in       in_valid / in_ready  func, data_word, first_field,          in
//                                last_field
//  out      out_valid/out_ready  digest                                out
//
// Bytes: a 64-bit word is mixed one byte per cycle through the single
//   XOR/multiply-by-prime unit (first byte on the accept cycle). A boolean,
//   an empty run or an unused selector is taken without any ST_MIX steps.
// Reset: rst is synchronous; the running hash returns to the offset basis and
//   the output register empties.
// Stalls: a finished digest sits in the output register while the next word
//   is taken; the core holds off input while it mixes the rest of a word
//   and when a second digest is ready while the first still waits.
// ----------------------------------------------------------------------------
module fnv1a64_record_hash_core
  import fnvrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input word channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [HASH_W-1:0] data_word,
  input  logic              first_field,
  input  logic              last_field,
  // digest channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] digest
);

  res_t res;
  logic slot_free;

  // Output slot can take a new digest when empty or being drained this cycle.
  assign slot_free = !out_valid || out_ready;

  fnvrh_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .data_word   (data_word),
    .first_field (first_field),
    .last_field  (last_field),
    .slot_free   (slot_free),
    .res         (res)
  );

  // Output register: valid flag is control, digest is payload only.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && slot_free) begin
      digest <= res.digest;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fnv1a64_record_hash_core. It drives record fields
// (64-bit words, booleans, empty runs, unused selectors) with random gaps on
// both channels. A digest scoreboard keeps its own running FNV-1a 64 hash and
// compares each digest taken from the core with the oldest expected value.
// ----------------------------------------------------------------------------
module testbench
  import fnvrh_pkg::*;
();

  // Tracks the running hash from the input words the core accepts, and holds
  // the digests that are still owed.
  class digest_scoreboard;
    localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01B3;

    logic [63:0] hash_state;
    logic [63:0] owed_digests[$];
    int unsigned mismatches;

    function new();
      hash_state = HASH_BASIS;
      mismatches = 0;
    endfunction

    function logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return x * HASH_PRIME;
    endfunction

    // Called once per accepted input word.
    function void note_field(func_t f, logic [63:0] w, logic first, logic last);
      case (f)
        FUNC_EMPTY: begin
          // empty run: digest of zero, flags don't matter
          hash_state = HASH_BASIS;
          owed_digests.push_back(64'd0);
        end
        FUNC_WORD, FUNC_BOOL: begin
          if (first) hash_state = HASH_BASIS;
          if (f == FUNC_WORD) begin
            for (int k = 0; k < 8; k++) hash_state = fold_byte(hash_state, w[8*k +: 8]);
          end else begin
            hash_state = fold_byte(hash_state, {7'd0, w[0]});
          end
          if (last) owed_digests.push_back(hash_state);
        end
        default: ;  // unused selector leaves everything alone
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task check_digest(logic [63:0] got);
      logic [63:0] want;
      if (owed_digests.size() == 0) begin
        report_mismatch($sformatf("digest %h with none expected", got));
      end else begin
        want = owed_digests.pop_front();
        if (got !== want)
          report_mismatch($sformatf("digest %h, expected %h", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        func = 2'd0;
  logic [HASH_W-1:0] data_word = '0;
  logic              first_field = 1'b0;
  logic              last_field = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HASH_W-1:0] digest;

  digest_scoreboard sb = new();

  int unsigned cycle_no = 0;
  bit          gapless = 1'b0;   // sender runs back to back while set

  fnv1a64_record_hash_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .data_word  (data_word),
    .first_field(first_field),
    .last_field (last_field),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest     (digest)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Digest side: every handshake seen at the edge goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_digest(digest);
  end

  // Mostly short gaps, a few long ones; none at all during gapless stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offer one input word and hold it until the core takes it. valid is left
  // high on return; a later gap or the end of stimulus lowers it.
  task automatic put_field(input func_t f, input logic [63:0] w,
                           input logic first, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    data_word   <= w;
    first_field <= first;
    last_field  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_field(f, w, first, last);
  endtask

  // Receiver: random ready runs and stalls, plus one long hold-off so the
  // output register fills and the core has to stall its input.
  initial begin : ready_driver
    int unsigned run_len;
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && cycle_no >= 3000) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                            : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      case ($urandom_range(0, 9))
        0, 1, 2: stall = 0;
        9:       stall = $urandom_range(15, 40);
        default: stall = $urandom_range(1, 4);
      endcase
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned fields_sent;
    int unsigned rec_len;
    func_t       f;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a word straight after reset without a first flag continues
    // from the offset basis.
    put_field(FUNC_WORD, 64'd0, 1'b0, 1'b1);
    // Emit without restart: the hash carries on into the next field.
    put_field(FUNC_BOOL, 64'd1, 1'b0, 1'b1);
    put_field(FUNC_WORD, '1, 1'b1, 1'b1);
    put_field(FUNC_WORD, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
    put_field(FUNC_WORD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    put_field(FUNC_BOOL, 64'd1, 1'b0, 1'b1);
    // Booleans with junk in the upper bits: only bit 0 counts.
    put_field(FUNC_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    put_field(FUNC_BOOL, 64'hA5A5_5A5A_0F0F_F0F1, 1'b1, 1'b1);
    // Empty runs with every flag combination and junk data.
    put_field(FUNC_EMPTY, 64'd0, 1'b0, 1'b0);
    put_field(FUNC_EMPTY, '1, 1'b1, 1'b1);
    put_field(FUNC_EMPTY, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0);
    put_field(FUNC_EMPTY, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1);
    // After an empty run the hash is back at the basis; continue without first.
    put_field(FUNC_WORD, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b1);
    // Unused selector must be ignored, flags included.
    put_field(FUNC_WORD, 64'hDEAD_BEEF_0000_0001, 1'b1, 1'b0);
    put_field(FUNC_SKIP, '1, 1'b1, 1'b1);
    put_field(FUNC_SKIP, 64'd0, 1'b0, 1'b0);
    put_field(FUNC_BOOL, 64'd0, 1'b0, 1'b1);
    put_field(FUNC_BOOL, 64'd0, 1'b1, 1'b0);
    put_field(FUNC_BOOL, 64'd1, 1'b0, 1'b0);
    put_field(FUNC_WORD, 64'h0000_0000_0000_00FF, 1'b0, 1'b1);

    // Random: mostly well-formed records, some loose fields and noise.
    fields_sent = 0;
    while (fields_sent < 1750) begin
      if ($urandom_range(0, 19) == 0) gapless = ~gapless;
      if ($urandom_range(0, 99) < 85) begin
        rec_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
                                             : $urandom_range(4, 8);
        for (int i = 0; i < rec_len; i++) begin
          f = ($urandom_range(0, 9) < 6) ? FUNC_WORD : FUNC_BOOL;
          put_field(f, pick_data(), i == 0, i == rec_len - 1);
          fields_sent++;
          if ($urandom_range(0, 29) == 0)
            put_field(FUNC_SKIP, pick_data(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
      end else begin
        f = func_t'($urandom_range(0, 3));
        put_field(f, pick_data(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        if (f != FUNC_SKIP) fields_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then give a late or extra digest time to show up.
    while (sb.owed_digests.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_digests.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
